>>> sv/hfpa_pkg.sv
// ----------------------------------------------------------------------------
// hfpa_pkg
// Shared constants, command codes and word types for the hop field
// pointer advance core.
// ----------------------------------------------------------------------------
`default_nettype none

package hfpa_pkg;

  localparam int STORE_BYTES = 256;
  localparam int FIELD_BYTES = 8;

  // store address width
  localparam int ADDR_W = $clog2(STORE_BYTES);
  // walk pointers: four fields past the last byte of an 8-bit offset
  localparam int PTR_W  = $clog2(256 + 4 * FIELD_BYTES);
  // segment limit: (hop count + 1) * FIELD_BYTES
  localparam int LIM_W  = $clog2(256 * FIELD_BYTES + 1);

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_SET     = 2'd1,
    CMD_INIT    = 2'd2,
    CMD_ADVANCE = 2'd3
  } cmd_t;

  localparam logic [1:0] CFG_PEER_MASK   = 2'd0;
  localparam logic [1:0] CFG_CROSS_MASK  = 2'd1;
  localparam logic [1:0] CFG_VERIFY_MASK = 2'd2;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] byte_addr;
    logic [7:0] byte_data;
  } in_word_t;

  typedef struct packed {
    logic [7:0] info_offset;
    logic [7:0] hop_offset;
    logic       status;
  } out_word_t;

endpackage

`default_nettype wire

>>> sv/hop_field_pointer_advance_core.sv
// ----------------------------------------------------------------------------
// hop_field_pointer_advance_core
// Packet byte store with info and hop field offsets; walks the hop offset
// to the next usable hop field on init and advance commands.
// ----------------------------------------------------------------------------
//
//  channel  signals                        direction  handshake
//  -------  -----------------------------  ---------  -------------------
//  in       in_valid, in_stall, in_word    input      valid & !stall
//  out      out_valid, out_stall, out_word output     valid & !stall
//  cfg      cfg_valid, cfg_ready,          input      valid & ready
//           cfg_index, cfg_data
//
//  Write byte and set offsets go straight to the result. Advance and init
//  take one more store read for each extra field stepped over (segment
//  changes and verify-only hop fields); the single read port of the
//  store, one byte per cycle, sets this. Synchronous reset clears offsets
//  and masks; store contents are undefined until written. The next word
//  is taken while a result still waits in the output register; a stalled
//  output only holds the core in its final state.
// ----------------------------------------------------------------------------
`default_nettype none

module hop_field_pointer_advance_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire hfpa_pkg::in_word_t   in_word,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      hfpa_pkg::out_word_t  out_word,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [7:0]           cfg_data
);
  import hfpa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT_A,
    S_INIT_B,
    S_HOPS,
    S_STEP,
    S_FLAG,
    S_DONE
  } state_t;

  localparam logic [PTR_W-1:0] FIELD_P = PTR_W'(FIELD_BYTES);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(FIELD_BYTES - 1);
  localparam logic [PTR_W-1:0] STORE_P = PTR_W'(STORE_BYTES);

  state_t           state_r;
  logic [7:0]       info_ptr_r;
  logic [7:0]       hop_ptr_r;
  logic [7:0]       peer_mask_r;
  logic [7:0]       cross_mask_r;
  logic [7:0]       verify_mask_r;
  logic [PTR_W-1:0] ip_r;
  logic [PTR_W-1:0] hp_r;
  logic [LIM_W-1:0] lim_r;
  logic [7:0]       fi_r;
  logic             status_r;
  logic             out_valid_r;
  out_word_t        out_word_r;

  logic [7:0]       mem [STORE_BYTES];
  logic [7:0]       rd_data_r;

  logic             in_accept;
  logic             out_free;
  logic             wr_en;
  logic             rd_en;
  logic [PTR_W-1:0] rd_ptr;
  logic             rd_ok;
  logic [PTR_W-1:0] info_w;
  logic [PTR_W-1:0] hop_step;
  logic [PTR_W:0]   diff;
  logic             exceed;
  logic             skip;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign cfg_ready = 1'b1;

  assign info_w   = PTR_W'(info_ptr_r);
  assign hop_step = hp_r + FIELD_P;
  assign diff     = {1'b0, hop_step} - {1'b0, ip_r};
  // field distance beyond hop count, negative distances never exceed
  assign exceed   = !diff[PTR_W] && (LIM_W'(diff[PTR_W-1:0]) >= lim_r);
  assign skip     = ((fi_r & peer_mask_r) != 8'd0) && ((rd_data_r & cross_mask_r) != 8'd0);

  assign wr_en = in_accept && (in_word.command == CMD_WRITE) &&
                 ({1'b0, in_word.byte_addr} < 9'(STORE_BYTES));

  always_comb begin
    rd_ptr = '0;
    rd_ok  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_word.command == CMD_INIT) begin
          rd_ptr = info_w;
          rd_ok  = (info_w + FIELD_P) < STORE_P;
        end else begin
          rd_ptr = info_w + LAST_P;
          rd_ok  = rd_ptr < STORE_P;
        end
      end
      S_INIT_A: begin
        rd_ptr = ip_r + FIELD_P;
        rd_ok  = 1'b1;
      end
      S_INIT_B: begin
        rd_ptr = ip_r + LAST_P;
        rd_ok  = 1'b1;
      end
      S_STEP: begin
        rd_ptr = exceed ? (hop_step + LAST_P) : hop_step;
        rd_ok  = rd_ptr < STORE_P;
      end
      default: begin
        rd_ptr = '0;
        rd_ok  = 1'b0;
      end
    endcase
  end

  assign rd_en = rd_ok && (state_r != S_IDLE || in_accept);

  // byte store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[in_word.byte_addr[ADDR_W-1:0]] <= in_word.byte_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_ptr[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peer_mask_r   <= '0;
      cross_mask_r  <= '0;
      verify_mask_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PEER_MASK:   peer_mask_r   <= cfg_data;
        CFG_CROSS_MASK:  cross_mask_r  <= cfg_data;
        CFG_VERIFY_MASK: verify_mask_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      info_ptr_r  <= '0;
      hop_ptr_r   <= '0;
      status_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            ip_r     <= info_w;
            hp_r     <= PTR_W'(hop_ptr_r);
            unique case (in_word.command)
              CMD_WRITE: begin
                status_r <= 1'b0;
                state_r  <= S_DONE;
              end
              CMD_SET: begin
                info_ptr_r <= in_word.byte_addr;
                hop_ptr_r  <= in_word.byte_data;
                status_r   <= 1'b0;
                state_r    <= S_DONE;
              end
              CMD_INIT: begin
                status_r <= !rd_ok;
                state_r  <= rd_ok ? S_INIT_A : S_DONE;
              end
              CMD_ADVANCE: begin
                status_r <= !rd_ok;
                state_r  <= rd_ok ? S_HOPS : S_DONE;
              end
            endcase
          end
        end
        S_INIT_A: begin
          fi_r    <= rd_data_r;
          state_r <= S_INIT_B;
        end
        S_INIT_B: begin
          if (skip) begin
            hp_r <= hop_step;
          end
          state_r <= S_HOPS;
        end
        S_HOPS: begin
          lim_r   <= (LIM_W'(rd_data_r) + LIM_W'(1)) * LIM_W'(FIELD_BYTES);
          state_r <= S_STEP;
        end
        S_STEP: begin
          hp_r <= hop_step;
          if (exceed) begin
            ip_r <= hop_step;
          end
          if (!rd_ok) begin
            // overrun: drop the walk, keep the offsets
            status_r <= 1'b1;
            state_r  <= S_DONE;
          end else begin
            state_r <= exceed ? S_HOPS : S_FLAG;
          end
        end
        S_FLAG: begin
          if ((rd_data_r & verify_mask_r) == 8'd0) begin
            info_ptr_r <= ip_r[7:0];
            hop_ptr_r  <= hp_r[7:0];
            state_r    <= S_DONE;
          end else begin
            state_r <= S_STEP;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_word_r.info_offset <= info_ptr_r;
            out_word_r.hop_offset  <= hop_ptr_r;
            out_word_r.status      <= status_r;
            out_valid_r            <= 1'b1;
            state_r                <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
